### rtl/core/mavg_pkg.sv
// Shared constants and types for the moving average filter core.
// No dependencies.
package mavg_pkg;

	localparam int LEN_BITS        = 7;
	localparam int DEF_MAX_WINDOW  = 64;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam logic [LEN_BITS-1:0] WINDOW_RESET = 7'd3;

	// side information that rides along the divider chain
	typedef struct packed {
		logic                neg;
		logic [LEN_BITS-1:0] held;
	} div_tag_t;

endpackage

### rtl/core/mavg_store.sv
// Sample ring store: one port, read-first, registered read data.
// Depends on nothing.
module mavg_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q   <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/mavg_div_cell.sv
// One restoring division cell: produces one quotient bit per pass.
// Depends on mavg_pkg.
module mavg_div_cell
	import mavg_pkg::*;
#(
	parameter int NUM_BITS = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [LEN_BITS-1:0] in_rem,
	input  logic [NUM_BITS-1:0] in_num,
	input  logic [NUM_BITS-1:0] in_quo,
	input  logic [LEN_BITS-1:0] in_div,
	input  div_tag_t            in_tag,
	output logic                out_valid,
	output logic [LEN_BITS-1:0] out_rem,
	output logic [NUM_BITS-1:0] out_num,
	output logic [NUM_BITS-1:0] out_quo,
	output logic [LEN_BITS-1:0] out_div,
	output div_tag_t            out_tag
);

	logic [LEN_BITS:0]   shifted;
	logic                ge;
	logic [LEN_BITS:0]   diff;
	logic                valid_q;
	logic [LEN_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] num_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [LEN_BITS-1:0] div_q;
	div_tag_t            tag_q;

	assign shifted = {in_rem, in_num[NUM_BITS-1]};
	assign ge      = shifted >= {1'b0, in_div};
	assign diff    = shifted - {1'b0, in_div};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= ge ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
		num_q <= {in_num[NUM_BITS-2:0], 1'b0};
		quo_q <= {in_quo[NUM_BITS-2:0], ge};
		div_q <= in_div;
		tag_q <= in_tag;
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_num   = num_q;
	assign out_quo   = quo_q;
	assign out_div   = div_q;
	assign out_tag   = tag_q;

endmodule

### rtl/core/mavg_divider.sv
// Unsigned divider built as a chain of restoring cells, one per quotient bit.
// Depends on mavg_pkg and mavg_div_cell.
module mavg_divider
	import mavg_pkg::*;
#(
	parameter int NUM_BITS = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [NUM_BITS-1:0] in_num,
	input  logic [LEN_BITS-1:0] in_div,
	input  div_tag_t            in_tag,
	output logic                out_valid,
	output logic [NUM_BITS-1:0] out_quo,
	output div_tag_t            out_tag
);

	logic                valid_c [NUM_BITS+1];
	logic [LEN_BITS-1:0] rem_c   [NUM_BITS+1];
	logic [NUM_BITS-1:0] num_c   [NUM_BITS+1];
	logic [NUM_BITS-1:0] quo_c   [NUM_BITS+1];
	logic [LEN_BITS-1:0] div_c   [NUM_BITS+1];
	div_tag_t            tag_c   [NUM_BITS+1];

	assign valid_c[0] = in_valid;
	assign rem_c[0]   = '0;
	assign num_c[0]   = in_num;
	assign quo_c[0]   = '0;
	assign div_c[0]   = in_div;
	assign tag_c[0]   = in_tag;

	for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
		mavg_div_cell #(
			.NUM_BITS(NUM_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_rem   (rem_c[i]),
			.in_num   (num_c[i]),
			.in_quo   (quo_c[i]),
			.in_div   (div_c[i]),
			.in_tag   (tag_c[i]),
			.out_valid(valid_c[i+1]),
			.out_rem  (rem_c[i+1]),
			.out_num  (num_c[i+1]),
			.out_quo  (quo_c[i+1]),
			.out_div  (div_c[i+1]),
			.out_tag  (tag_c[i+1])
		);
	end

	assign out_valid = valid_c[NUM_BITS];
	assign out_quo   = quo_c[NUM_BITS];
	assign out_tag   = tag_c[NUM_BITS];

endmodule

### rtl/core/moving_average_filter_core.sv
// Moving average filter core: ring store, running sum and divider chain.
// Depends on mavg_pkg, mavg_store and mavg_divider.
//
//  channel  | dir | fields (low bit up)
//  s_*      | in  | tdata: sample
//  m_*      | out | tdata: mean, samples_held
//  cfg_*    | in  | wdata: window_length
//
// One word in flight: after accept the word passes the stage-1 registers, the divider
// chain (one quotient bit per cell), the holding register and the output register before
// m_tvalid rises; s_tready returns once the result leaves the holding register.
// The next word is accepted while a finished result waits on m_*; its own result then
// waits in the holding register, and s_tready stays low until m_* takes the older one.
// Reset clears the fill count, sum and position; window_length resets to 3.
// A window_length write clears the same state.
module moving_average_filter_core
	import mavg_pkg::*;
#(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	localparam int S_W = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int M_W = ((SAMPLE_BITS + LEN_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_W-1:0]      s_tdata,   // sample
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_W-1:0]      m_tdata,   // mean, samples_held
	input  logic                cfg_we,
	input  logic [LEN_BITS-1:0] cfg_wdata  // window_length
);

	localparam int PTR_W    = $clog2(MAX_WINDOW);
	localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

	logic [LEN_BITS-1:0]           wlen_q;
	logic [LEN_BITS-1:0]           fill_q;
	logic [PTR_W-1:0]              pos_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic                          busy_q;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          full_s1;
	logic [LEN_BITS-1:0]           held_s1;

	logic                          pend_valid_q;
	logic [SAMPLE_BITS-1:0]        pend_mean_q;
	logic [LEN_BITS-1:0]           pend_held_q;
	logic                          out_valid_q;
	logic [SAMPLE_BITS-1:0]        out_mean_q;
	logic [LEN_BITS-1:0]           out_held_q;

	logic                          accept;
	logic [LEN_BITS-1:0]           w_eff;
	logic [PTR_W-1:0]              pos_cur;
	logic [PTR_W-1:0]              pos_nx;
	logic                          full;
	logic [LEN_BITS-1:0]           fill_nx;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SUM_BITS-1:0]    old_ext;
	logic signed [SUM_BITS-1:0]    sum_new;
	logic [SUM_BITS-1:0]           sum_mag;
	div_tag_t                      div_tag_in;
	logic                          div_valid;
	logic [SUM_BITS-1:0]           div_quo;
	div_tag_t                      div_tag;
	logic [SAMPLE_BITS-1:0]        q_mag;
	logic [SAMPLE_BITS-1:0]        mean_calc;
	logic                          out_free;
	logic                          move_out;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (wlen_q == '0) begin
			w_eff = LEN_BITS'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			w_eff = LEN_BITS'(MAX_WINDOW);
		end else begin
			w_eff = wlen_q;
		end
	end

	assign pos_cur = (32'(pos_q) >= 32'(w_eff)) ? '0 : pos_q;
	assign pos_nx  = (32'(pos_cur) + 32'd1 >= 32'(w_eff)) ? '0 : pos_cur + 1'b1;
	assign full    = !(fill_q < w_eff);
	assign fill_nx = full ? fill_q : fill_q + 1'b1;

	mavg_store #(
		.DEPTH(MAX_WINDOW),
		.WIDTH(SAMPLE_BITS)
	) u_store (
		.clk  (clk),
		.en   (accept),
		.addr (pos_cur),
		.wdata(s_tdata[SAMPLE_BITS-1:0]),
		.rdata(rd_data)
	);

	assign old_ext = full_s1 ? SUM_BITS'($signed(rd_data)) : '0;
	assign sum_new = sum_q - old_ext + SUM_BITS'(x_s1);
	assign sum_mag = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : SUM_BITS'(sum_new);

	assign div_tag_in.neg  = sum_new[SUM_BITS-1];
	assign div_tag_in.held = held_s1;

	mavg_divider #(
		.NUM_BITS(SUM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_num   (sum_mag),
		.in_div   (held_s1),
		.in_tag   (div_tag_in),
		.out_valid(div_valid),
		.out_quo  (div_quo),
		.out_tag  (div_tag)
	);

	assign q_mag     = div_quo[SAMPLE_BITS-1:0];
	assign mean_calc = div_tag.neg ? -q_mag : q_mag;

	assign out_free = !out_valid_q || m_tready;
	assign move_out = pend_valid_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q       <= WINDOW_RESET;
			fill_q       <= '0;
			pos_q        <= '0;
			sum_q        <= '0;
			busy_q       <= 1'b0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg_we) begin
				wlen_q <= cfg_wdata;
				fill_q <= '0;
				pos_q  <= '0;
				sum_q  <= '0;
			end else begin
				if (accept) begin
					fill_q <= fill_nx;
					pos_q  <= pos_nx;
				end
				if (valid_s1) begin
					sum_q <= sum_new;
				end
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move_out) begin
				busy_q <= 1'b0;
			end
			if (div_valid) begin
				pend_valid_q <= 1'b1;
			end else if (move_out) begin
				pend_valid_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= $signed(s_tdata[SAMPLE_BITS-1:0]);
			full_s1 <= full;
			held_s1 <= fill_nx;
		end
		if (div_valid) begin
			pend_mean_q <= mean_calc;
			pend_held_q <= div_tag.held;
		end
		if (move_out) begin
			out_mean_q <= pend_mean_q;
			out_held_q <= pend_held_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_W'({out_held_q, out_mean_q});

endmodule
